// ===== hdl/moac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// moac_pkg: shared types and codes for the median offset axis correction
// Item layouts, operation and result kinds, map codes and register indexes.
// ----------------------------------------------------------------------------
package moac_pkg;

  // Default number of calibration samples per round
  localparam int SAMPLES_DEFAULT = 64;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_THIRD  = 2'd2;

  // Axis slot codes; the remaining code drops the word
  localparam logic [1:0] MAP_X = 2'd0;
  localparam logic [1:0] MAP_Y = 2'd1;
  localparam logic [1:0] MAP_Z = 2'd2;

  // Operation codes of an input item
  localparam logic OP_CALIB = 1'b0;
  localparam logic OP_MEAS  = 1'b1;

  // Result kinds
  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_OFFS = 1'b1;

  typedef logic signed [15:0] word_t;

  // Three slot values, element 0 is x
  typedef word_t [2:0] axes_t;

  typedef struct packed {
    logic  op;
    word_t word_first;
    word_t word_second;
    word_t word_third;
  } in_item_t;

  typedef struct packed {
    logic  kind;
    word_t axis_x;
    word_t axis_y;
    word_t axis_z;
  } out_item_t;

  // Requests from the input side to the merge stage
  typedef struct packed {
    logic meas_go;  // measurement item accepted
    logic cal_go;   // last calibration item of a round accepted
  } merge_req_t;

  // Status from the merge stage back to the input side
  typedef struct packed {
    logic pend;       // offsets waiting to be read from the lanes
    logic out_valid;  // result register holds an item
  } merge_sts_t;

endpackage : moac_pkg
`default_nettype wire

// ===== hdl/median_offset_axis_correction_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// median_offset_axis_correction_core: three-axis median offset calibration
// Remaps device words to axis slots, finds per-axis median offsets over a
// calibration round and subtracts them from measurement items.
// ----------------------------------------------------------------------------
// A measurement item or an ordinary calibration item is accepted whenever
// in_ready is high, so items may follow back to back while the result
// register drains; a result that is not taken holds the input until
// out_ready rises. The last calibration item of a round is inserted into
// the three sort chains and sets the pending flag; the medians are then
// read from the middle cell of each chain into the offset and result
// registers once the result register is free, and until then no item is
// accepted. Each axis lane is a chain of SAMPLES 16-bit cells that keeps
// the round's samples sorted, one insert a cycle while calibration items
// are accepted; the three chains hold 48 * SAMPLES flip-flops.
// Configuration writes take effect at the edge where cfg_we is high; index 3 is ignored.
// ----------------------------------------------------------------------------
module median_offset_axis_correction_core #(
  parameter int SAMPLES = moac_pkg::SAMPLES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire moac_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output moac_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_we,
  input  wire logic [moac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [moac_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES - 1);

  logic [1:0]           map_first_r, map_second_r, map_third_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  moac_pkg::axes_t      slot;
  moac_pkg::axes_t      med;
  moac_pkg::merge_req_t req;
  moac_pkg::merge_sts_t sts;
  logic                 accept;
  logic                 cal_ins;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_first_r  <= moac_pkg::MAP_X;
      map_second_r <= moac_pkg::MAP_Y;
      map_third_r  <= moac_pkg::MAP_Z;
    end else if (cfg_we) begin
      case (cfg_index)
        moac_pkg::CFG_MAP_FIRST:  map_first_r  <= cfg_data;
        moac_pkg::CFG_MAP_SECOND: map_second_r <= cfg_data;
        moac_pkg::CFG_MAP_THIRD:  map_third_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Place device words in slots; the later word wins, an unwritten slot is zero
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (map_third_r == 2'(a)) begin
        slot[a] = in_item.word_third;
      end else if (map_second_r == 2'(a)) begin
        slot[a] = in_item.word_second;
      end else if (map_first_r == 2'(a)) begin
        slot[a] = in_item.word_first;
      end else begin
        slot[a] = '0;
      end
    end
  end

  // Hold the input while offsets are pending or the result cannot move
  assign in_ready = !sts.pend && (!sts.out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign cal_ins  = accept && (in_item.op == moac_pkg::OP_CALIB);

  assign req.meas_go = accept && (in_item.op == moac_pkg::OP_MEAS);
  assign req.cal_go  = cal_ins && (count_r == LAST);

  // Round fill count, restart after the last sample
  always_comb begin
    count_nxt = count_r;
    if (cal_ins) begin
      count_nxt = (count_r == LAST) ? '0 : count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // One sort lane per axis
  for (genvar a = 0; a < 3; a++) begin : g_lane
    moac_sort_lane #(
      .SAMPLES (SAMPLES),
      .CNT_W   (CNT_W)
    ) u_lane (
      .clk    (clk),
      .ins_i  (cal_ins),
      .fill_i (count_r),
      .val_i  (slot[a]),
      .med_o  (med[a])
    );
  end

  moac_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (req),
    .slot_i    (slot),
    .med_i     (med),
    .out_ready (out_ready),
    .sts_o     (sts),
    .out_item  (out_item)
  );

  assign out_valid = sts.out_valid;

endmodule : median_offset_axis_correction_core
`default_nettype wire

// ===== hdl/moac_sort_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// moac_sort_lane: insertion-sort cell chain for one axis
// Keeps the samples of a round in ascending order; one insert per cycle.
// ----------------------------------------------------------------------------
module moac_sort_lane #(
  parameter int SAMPLES = moac_pkg::SAMPLES_DEFAULT,
  parameter int CNT_W   = $clog2(SAMPLES + 1)
) (
  input  wire logic               clk,
  input  wire logic               ins_i,
  input  wire logic [CNT_W-1:0]   fill_i,
  input  wire moac_pkg::word_t    val_i,
  output moac_pkg::word_t         med_o
);

  localparam int MED = SAMPLES / 2;

  moac_pkg::word_t   cell_r   [SAMPLES];
  moac_pkg::word_t   cell_nxt [SAMPLES];
  logic [SAMPLES-1:0] gt;

  // Each cell decides on its own whether it moves up; empty cells count as above
  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    assign gt[i] = (CNT_W'(i) >= fill_i) || (cell_r[i] > val_i);

    if (i == 0) begin : g_first
      always_comb begin
        cell_nxt[i] = gt[i] ? val_i : cell_r[i];
      end
    end else begin : g_rest
      // take the lower neighbour while it moves too, else the new value
      always_comb begin
        cell_nxt[i] = cell_r[i];
        if (gt[i]) begin
          cell_nxt[i] = gt[i-1] ? cell_r[i-1] : val_i;
        end
      end
    end
  end

  // Advance the chain on insert
  always_ff @(posedge clk) begin
    if (ins_i) begin
      cell_r <= cell_nxt;
    end
  end

  assign med_o = cell_r[MED];

endmodule : moac_sort_lane
`default_nettype wire

// ===== hdl/moac_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// moac_merge: offset store and result register
// Combines the lane medians into new offsets and corrects measurements.
// ----------------------------------------------------------------------------
module moac_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire moac_pkg::merge_req_t req_i,
  input  wire moac_pkg::axes_t     slot_i,
  input  wire moac_pkg::axes_t     med_i,
  input  wire logic                out_ready,
  output moac_pkg::merge_sts_t     sts_o,
  output moac_pkg::out_item_t      out_item
);

  logic                 pend_r,      pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  moac_pkg::out_item_t  out_item_r,  out_item_nxt;
  moac_pkg::axes_t      offs_r,      offs_nxt;
  moac_pkg::axes_t      corr;
  logic                 out_free;

  // Wrap-around correction of each slot
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      corr[a] = slot_i[a] - offs_r[a];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Load offsets or a corrected item, drop the result once taken
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    offs_nxt      = offs_r;
    if (pend_r && out_free) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      offs_nxt      = med_i;
      out_item_nxt  = '{kind: moac_pkg::KIND_OFFS, axis_x: med_i[0],
                        axis_y: med_i[1], axis_z: med_i[2]};
    end else if (req_i.meas_go) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = '{kind: moac_pkg::KIND_MEAS, axis_x: corr[0],
                        axis_y: corr[1], axis_z: corr[2]};
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (req_i.cal_go) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      offs_r      <= '0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      offs_r      <= offs_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign sts_o.pend      = pend_r;
  assign sts_o.out_valid = out_valid_r;
  assign out_item        = out_item_r;

endmodule : moac_merge
`default_nettype wire
